// ----- rtl/i2r_pkg.sv -----
// Types, constants and pattern tables for the integer to Roman numeral converter.
`default_nettype none

package i2r_pkg;

	localparam logic signed [15:0] VAL_LO = 16'sd1;
	localparam logic signed [15:0] VAL_HI = 16'sd3000;

	localparam logic [7:0] CH_M  = 8'h4D;
	localparam logic [7:0] CH_D  = 8'h44;
	localparam logic [7:0] CH_C  = 8'h43;
	localparam logic [7:0] CH_L  = 8'h4C;
	localparam logic [7:0] CH_X  = 8'h58;
	localparam logic [7:0] CH_V  = 8'h56;
	localparam logic [7:0] CH_I  = 8'h49;
	localparam logic [7:0] CH_NL = 8'h0A;
	localparam logic [7:0] CH_NONE = 8'h00;

	typedef enum logic [1:0] {
		PL_THOU = 2'd0,
		PL_HUND = 2'd1,
		PL_TENS = 2'd2,
		PL_UNIT = 2'd3
	} i2r_place_t;

	localparam logic [2:0] DIG_NL = 3'd4;

	typedef enum logic [1:0] {
		K_ONE  = 2'd0,
		K_FIVE = 2'd1,
		K_TEN  = 2'd2
	} i2r_kind_t;

	typedef struct packed {
		logic       invalid;
		logic [1:0] thou;
		logic [3:0] hund;
		logic [3:0] tens;
		logic [3:0] unit;
	} i2r_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} i2r_qstat_t;

	function automatic logic [2:0] pat_len(input logic [3:0] d);
		logic [2:0] len;
		unique case (d)
			4'd0:    len = 3'd0;
			4'd1:    len = 3'd1;
			4'd2:    len = 3'd2;
			4'd3:    len = 3'd3;
			4'd4:    len = 3'd2;
			4'd5:    len = 3'd1;
			4'd6:    len = 3'd2;
			4'd7:    len = 3'd3;
			4'd8:    len = 3'd4;
			4'd9:    len = 3'd2;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic i2r_kind_t pat_kind(input logic [3:0] d, input logic [1:0] pos);
		i2r_kind_t k;
		unique case (d)
			4'd9:                      k = (pos == 2'd0) ? K_ONE : K_TEN;
			4'd4:                      k = (pos == 2'd0) ? K_ONE : K_FIVE;
			4'd5, 4'd6, 4'd7, 4'd8:    k = (pos == 2'd0) ? K_FIVE : K_ONE;
			default:                   k = K_ONE;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] place_sym(input i2r_place_t pl, input i2r_kind_t k);
		logic [7:0] s;
		s = CH_NONE;
		unique case (pl)
			PL_THOU: s = CH_M;
			PL_HUND: begin
				unique case (k)
					K_ONE:   s = CH_C;
					K_FIVE:  s = CH_D;
					default: s = CH_M;
				endcase
			end
			PL_TENS: begin
				unique case (k)
					K_ONE:   s = CH_X;
					K_FIVE:  s = CH_L;
					default: s = CH_C;
				endcase
			end
			PL_UNIT: begin
				unique case (k)
					K_ONE:   s = CH_I;
					K_FIVE:  s = CH_V;
					default: s = CH_X;
				endcase
			end
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/i2r_in_if.sv -----
// Input channel: one signed integer per item.
`default_nettype none

interface i2r_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// ----- rtl/i2r_out_if.sv -----
// Output channel: one character per item.
`default_nettype none

interface i2r_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] symbol;
	logic       invalid;
	logic       last;

	modport source (output valid, output symbol, output invalid, output last, input ready);
	modport sink   (input valid, input symbol, input invalid, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/integer_to_roman_numeral.sv -----
// Top level of the integer to Roman numeral converter.
//
//  channel  role    fields                           per item
//  num      sink    value[15:0] signed               one integer
//  chr      source  symbol[7:0], invalid, last       one character
//
// The front takes an item every cycle unless the queue is full and stage three
// holds an item; three stages check the range and split the digits, then the
// item waits in the queue. The back steps through each digit's pattern, with a
// character per symbol, a silent step per zero digit, then the newline; an
// out-of-range item gives one flagged character. Reset clears all valid and
// pointer state at once. A stall on chr holds the back, and so the front.
`default_nettype none

module integer_to_roman_numeral
	import i2r_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	i2r_in_if.sink    num,
	i2r_out_if.source chr
);

	i2r_entry_t push_data;
	i2r_entry_t pop_data;
	i2r_qstat_t qstat;
	logic       push;
	logic       pop;

	i2r_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.num       (num),
		.qstat     (qstat),
		.push_data (push_data),
		.push      (push)
	);

	i2r_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.qstat     (qstat)
	);

	i2r_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_data (pop_data),
		.qstat    (qstat),
		.pop      (pop),
		.chr      (chr)
	);

endmodule

`default_nettype wire

// ----- rtl/i2r_front.sv -----
// Front end: range check and decimal digit split over three pipeline stages.
`default_nettype none

module i2r_front
	import i2r_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	i2r_in_if.sink          num,
	input  wire i2r_qstat_t qstat,
	output i2r_entry_t      push_data,
	output logic            push
);

	logic       en;
	logic       v_s1, v_s2, v_s3;
	logic       inv_s1, inv_s2;
	logic [1:0] th_s1, th_s2;
	logic [9:0] r1_s1;
	logic [3:0] hu_s2;
	logic [6:0] r2_s2;
	i2r_entry_t ent_s3;

	logic [11:0] n;
	logic [1:0]  th_c;
	logic [11:0] th_base;
	logic        inv_c;
	logic [3:0]  hu_c;
	logic [3:0]  te_c;

	assign en        = !v_s3 || !qstat.full;
	assign num.ready = en;
	assign push      = v_s3 && !qstat.full;
	assign push_data = ent_s3;

	always_comb begin
		n     = num.value[11:0];
		inv_c = (num.value < VAL_LO) || (num.value > VAL_HI);
		priority if (n >= 12'd3000) begin
			th_c    = 2'd3;
			th_base = 12'd3000;
		end else if (n >= 12'd2000) begin
			th_c    = 2'd2;
			th_base = 12'd2000;
		end else if (n >= 12'd1000) begin
			th_c    = 2'd1;
			th_base = 12'd1000;
		end else begin
			th_c    = 2'd0;
			th_base = 12'd0;
		end
	end

	always_comb begin
		hu_c = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (r1_s1 >= 10'(k * 100)) hu_c = 4'(k);
		end
	end

	always_comb begin
		te_c = 4'd0;
		for (int k = 1; k < 10; k++) begin
			if (r2_s2 >= 7'(k * 10)) te_c = 4'(k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= num.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s1 <= inv_c;
			th_s1  <= th_c;
			r1_s1  <= 10'(n - th_base);

			inv_s2 <= inv_s1;
			th_s2  <= th_s1;
			hu_s2  <= hu_c;
			r2_s2  <= 7'(r1_s1 - 10'(hu_c) * 10'd100);

			ent_s3.invalid <= inv_s2;
			ent_s3.thou    <= th_s2;
			ent_s3.hund    <= hu_s2;
			ent_s3.tens    <= te_c;
			ent_s3.unit    <= 4'(r2_s2 - 7'(te_c) * 7'd10);
		end
	end

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("front pushed into a full queue");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && qstat.full) |=> (v_s3 && $stable(ent_s3)))
		else $error("front stage three lost its entry under stall");

	a_valid_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !push_data.invalid) |->
			(push_data.hund < 4'd10 && push_data.tens < 4'd10 && push_data.unit < 4'd10))
		else $error("front produced a digit above nine");

endmodule

`default_nettype wire

// ----- rtl/i2r_fifo.sv -----
// Short queue of classified items between front and back.
`default_nettype none

module i2r_fifo
	import i2r_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire i2r_entry_t push_data,
	input  wire logic       pop,
	output i2r_entry_t      pop_data,
	output i2r_qstat_t      qstat
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	i2r_entry_t    mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign qstat.full  = (cnt_q == CNT_FULL);
	assign qstat.empty = (cnt_q == '0);
	assign pop_data    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PW'(1);
			if (pop)  rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PW'(1);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("queue count above depth");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/i2r_back.sv -----
// Back end: steps through the digit patterns and emits their characters in order.
`default_nettype none

module i2r_back
	import i2r_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire i2r_entry_t pop_data,
	input  wire i2r_qstat_t qstat,
	output logic            pop,
	i2r_out_if.source       chr
);

	logic       busy_q;
	i2r_entry_t ent_q;
	logic [2:0] dig_q;
	logic [1:0] pos_q;
	logic       ov_q;
	logic [7:0] sym_q;
	logic       inv_q;
	logic       last_q;

	logic       load_ok;
	logic [3:0] d;
	logic [2:0] len;
	logic       emit, done;
	logic [7:0] e_sym;
	logic       e_inv, e_last;
	logic [2:0] dig_n;
	logic [1:0] pos_n;

	assign chr.valid   = ov_q;
	assign chr.symbol  = sym_q;
	assign chr.invalid = inv_q;
	assign chr.last    = last_q;

	assign load_ok = !ov_q || chr.ready;
	assign pop     = !qstat.empty && (!busy_q || done);

	always_comb begin
		unique case (i2r_place_t'(dig_q[1:0]))
			PL_THOU: d = {2'b00, ent_q.thou};
			PL_HUND: d = ent_q.hund;
			PL_TENS: d = ent_q.tens;
			PL_UNIT: d = ent_q.unit;
		endcase
		len = pat_len(d);
	end

	always_comb begin
		emit   = 1'b0;
		done   = 1'b0;
		e_sym  = CH_NONE;
		e_inv  = 1'b0;
		e_last = 1'b0;
		dig_n  = dig_q;
		pos_n  = pos_q;
		if (busy_q && load_ok) begin
			priority if (ent_q.invalid) begin
				emit   = 1'b1;
				e_inv  = 1'b1;
				e_last = 1'b1;
				done   = 1'b1;
			end else if (dig_q == DIG_NL) begin
				emit   = 1'b1;
				e_sym  = CH_NL;
				e_last = 1'b1;
				done   = 1'b1;
			end else if (3'(pos_q) < len) begin
				emit  = 1'b1;
				e_sym = place_sym(i2r_place_t'(dig_q[1:0]), pat_kind(d, pos_q));
				if (3'(pos_q) + 3'd1 == len) begin
					dig_n = dig_q + 3'd1;
					pos_n = 2'd0;
				end else begin
					pos_n = pos_q + 2'd1;
				end
			end else begin
				dig_n = dig_q + 3'd1;
				pos_n = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			dig_q  <= '0;
			pos_q  <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				dig_q  <= '0;
				pos_q  <= '0;
			end else begin
				if (done) busy_q <= 1'b0;
				dig_q <= dig_n;
				pos_q <= pos_n;
			end
			if (load_ok) ov_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) ent_q <= pop_data;
		if (emit) begin
			sym_q  <= e_sym;
			inv_q  <= e_inv;
			last_q <= e_last;
		end
	end

	a_invalid_form: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && inv_q) |-> (sym_q == CH_NONE && last_q))
		else $error("invalid item with a character or without last");

	a_dig_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (dig_q <= DIG_NL))
		else $error("digit index past newline");

	a_emit_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (busy_q && load_ok))
		else $error("character emitted without a live entry");

endmodule

`default_nettype wire

// ----- sim/tb_integer_to_roman_numeral.sv -----
// Testbench for the integer to Roman numeral converter: directed and random values, checked per character.
`default_nettype none

module tb_integer_to_roman_numeral;
	import i2r_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS    = 10;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 200;
	localparam int TAIL_CYCLES    = 24;
	localparam int PHASE_ITEMS    = 21;
	localparam int BURST_ITEMS    = 12;

	typedef struct {
		logic [7:0] symbol;
		logic       invalid;
		logic       last;
	} roman_char_t;

	class roman_scoreboard;
		roman_char_t expected_chars[$];
		int mismatches;
		int chars_checked;
		int values_noted;
		int invalid_noted;

		function void push_char(logic [7:0] s, logic inv, logic lst);
			roman_char_t c;
			c.symbol  = s;
			c.invalid = inv;
			c.last    = lst;
			expected_chars.push_back(c);
		endfunction

		function void push_digit(int d, logic [7:0] one, logic [7:0] five, logic [7:0] ten);
			int reps;
			case (d)
				9: begin
					push_char(one, 1'b0, 1'b0);
					push_char(ten, 1'b0, 1'b0);
				end
				4: begin
					push_char(one, 1'b0, 1'b0);
					push_char(five, 1'b0, 1'b0);
				end
				default: begin
					reps = d;
					if (d >= 5) begin
						push_char(five, 1'b0, 1'b0);
						reps = d - 5;
					end
					repeat (reps) push_char(one, 1'b0, 1'b0);
				end
			endcase
		endfunction

		function void note_value(logic signed [15:0] v);
			int n;
			values_noted++;
			if (v < VAL_LO || v > VAL_HI) begin
				invalid_noted++;
				push_char(CH_NONE, 1'b1, 1'b1);
				return;
			end
			n = v;
			push_digit(n / 1000, CH_M, CH_M, CH_M);
			push_digit((n / 100) % 10, CH_C, CH_D, CH_M);
			push_digit((n / 10) % 10, CH_X, CH_L, CH_C);
			push_digit(n % 10, CH_I, CH_V, CH_X);
			push_char(CH_NL, 1'b0, 1'b1);
		endfunction

		function void check_char(logic [7:0] s, logic inv, logic lst);
			roman_char_t want;
			chars_checked++;
			if (expected_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected character: symbol %h invalid %b last %b",
						s, inv, lst);
				return;
			end
			want = expected_chars.pop_front();
			if (s !== want.symbol || inv !== want.invalid || lst !== want.last) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch: expected symbol %h invalid %b last %b, got %h %b %b",
						want.symbol, want.invalid, want.last, s, inv, lst);
			end
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	i2r_in_if  num_if ();
	i2r_out_if chr_if ();

	integer_to_roman_numeral u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_if),
		.chr    (chr_if)
	);

	roman_scoreboard sb = new();

	int send_idle_pct;
	int stall_pct;
	bit hold_off_req;
	int hold_left;
	int idle_cycles;
	bit hold_done;

	logic signed [15:0] directed_values [24] = '{
		16'sd1, 16'sd3, 16'sd4, 16'sd5, 16'sd8, 16'sd9, 16'sd10, 16'sd14,
		16'sd40, 16'sd49, 16'sd90, 16'sd100, 16'sd400, 16'sd900, 16'sd999, 16'sd1000,
		16'sd1994, 16'sd2888, 16'sd3000, 16'sd3001, 16'sd0, 16'shFFFF, 16'sh8000,
		16'sh7FFF
	};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic signed [15:0] random_value();
		int pick;
		logic signed [15:0] r;
		pick = $urandom_range(99);
		if (pick < 75)
			r = 16'($urandom_range(3000, 1));
		else if (pick < 82)
			r = 16'($urandom_range(3003, 2997));
		else if (pick < 88)
			r = 16'(int'($urandom_range(6)) - 3);
		else
			r = 16'($urandom);
		return r;
	endfunction

	task automatic send_value(input logic signed [15:0] v);
		int gap;
		num_if.valid <= 1'b1;
		num_if.value <= v;
		do @(posedge clk); while (!num_if.ready);
		sb.note_value(v);
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			num_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		num_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// receiver: check each item, then choose ready for the next cycle
	initial begin
		chr_if.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (chr_if.valid && chr_if.ready)
				sb.check_char(chr_if.symbol, chr_if.invalid, chr_if.last);
			if (hold_off_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				chr_if.ready <= 1'b0;
			end else if (arst_n) begin
				chr_if.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((num_if.valid && num_if.ready) || (chr_if.valid && chr_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles, %0d characters pending",
					idle_cycles, sb.pending());
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int send_pcts [4];
		int stall_pcts [4];
		arst_n = 1'b0;
		num_if.valid = 1'b0;
		num_if.value = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_off_req = 1'b0;
		hold_done = 1'b0;
		send_pcts  = '{0, 61, 0, 8};
		stall_pcts = '{0, 0, 61, 8};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_values[i]) send_value(directed_values[i]);
		drain();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_pcts[p];
			stall_pct = stall_pcts[p];
			if (p == 0) begin
				// stall the output while items keep coming, so the input backs up
				hold_off_req = 1'b1;
				repeat (BURST_ITEMS) send_value(random_value());
			end
			repeat (PHASE_ITEMS) send_value(random_value());
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Converted %0d values (%0d out of range) into %0d checked characters,",
			sb.values_noted, sb.invalid_noted, sb.chars_checked);
		$display("over four idling phases and one long output stall; %0d mismatches.",
			sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
